### rtl/core/lome_pkg.sv
// shared types and constants of the limit order matching engine
package lome_pkg;

  localparam int ORDER_CAPACITY = 64;
  localparam int PRICE_BITS     = 16;
  localparam int IDX_W          = $clog2(ORDER_CAPACITY);
  localparam int CNT_W          = $clog2(ORDER_CAPACITY + 1);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic {
    SIDE_BID = 1'b0,
    SIDE_ASK = 1'b1
  } side_e;

  typedef enum logic [2:0] {
    KIND_TRADE     = 3'd0,
    KIND_ADD       = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_CLEARED   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    REST_NONE    = 2'd0,
    REST_RESTED  = 2'd1,
    REST_DROPPED = 2'd2
  } rest_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_B,
    ST_DRAIN_B,
    ST_MATCH,
    ST_SCAN_I,
    ST_DRAIN_I,
    ST_RESOLVE,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_e;

  typedef struct packed {
    cmd_e                  command;
    side_e                 side;
    logic [PRICE_BITS-1:0] price;
    logic [31:0]           quantity;
    logic [31:0]           oid;
    logic [31:0]           order_seq;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_t;

  typedef struct packed {
    side_e                 side;
    logic [PRICE_BITS-1:0] price;
    logic [31:0]           quantity;
    logic [31:0]           oid;
    logic [31:0]           order_seq;
    logic [31:0]           arrival;
  } entry_t;

  typedef struct packed {
    logic [31:0]           trade_no;
    logic [PRICE_BITS-1:0] price;
    logic [31:0]           quantity;
    logic [31:0]           maker_id;
  } fill_t;

  typedef struct packed {
    kind_e                 kind;
    logic [31:0]           trade_no;
    logic [PRICE_BITS-1:0] trade_price;
    logic [31:0]           trade_quantity;
    logic [31:0]           taker_id;
    logic [31:0]           maker_id;
    rest_e                 rest_status;
    logic [31:0]           rested_quantity;
    logic                  last;
    logic [CNT_W-1:0]      bid_orders;
    logic [CNT_W-1:0]      ask_orders;
  } result_t;

endpackage

### rtl/core/lome_if.sv
// command and result channel interfaces
interface lome_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        side;
  logic [15:0] price;
  logic [31:0] quantity;
  logic [31:0] oid;
  logic [31:0] order_seq;

  modport source (output valid, command, side, price, quantity, oid, order_seq,
                  input ready);
  modport sink (input valid, command, side, price, quantity, oid, order_seq,
                output ready);
endinterface

interface lome_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] trade_no;
  logic [15:0] trade_price;
  logic [31:0] trade_quantity;
  logic [31:0] taker_id;
  logic [31:0] maker_id;
  logic [1:0]  rest_status;
  logic [31:0] rested_quantity;
  logic        last;
  logic [6:0]  bid_orders;
  logic [6:0]  ask_orders;

  modport source (output valid, kind, trade_no, trade_price, trade_quantity, taker_id,
                  maker_id, rest_status, rested_quantity, last, bid_orders, ask_orders,
                  input ready);
  modport sink (input valid, kind, trade_no, trade_price, trade_quantity, taker_id,
                maker_id, rest_status, rested_quantity, last, bid_orders, ask_orders,
                output ready);
endinterface

### rtl/core/lome_front.sv
// command intake: accepts, filters unknown commands and queues work for the engine
module lome_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  lome_req_if.sink        req_i,
  output lome_pkg::fq_t   deq_o,
  input  logic            deq_ready_i
);
  import lome_pkg::*;

  item_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QPTR_W:0]   fill_q, fill_d;
  logic              known, push, pop;
  item_t             item_in;

  assign known = (req_i.command == CMD_ADD) || (req_i.command == CMD_CANCEL) ||
                 (req_i.command == CMD_CLEAR);
  assign req_i.ready = fill_q != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign push = req_i.valid && req_i.ready && known;
  assign pop  = deq_o.valid && deq_ready_i;

  always_comb begin
    item_in.command   = cmd_e'(req_i.command);
    item_in.side      = side_e'(req_i.side);
    item_in.price     = req_i.price[PRICE_BITS-1:0];
    item_in.quantity  = req_i.quantity;
    item_in.oid       = req_i.oid;
    item_in.order_seq = req_i.order_seq;
  end

  assign deq_o.valid = fill_q != '0;
  assign deq_o.item  = slot_q[rptr_q];

  always_comb begin
    wptr_d = push ? wptr_q + QPTR_W'(1) : wptr_q;
    rptr_d = pop ? rptr_q + QPTR_W'(1) : rptr_q;
    fill_d = fill_q + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= item_in;
    end
  end

endmodule

### rtl/core/lome_back.sv
// matching engine: order store, best price and id scans, trade buffer and result output
module lome_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lome_pkg::fq_t   deq_i,
  output logic            deq_ready_o,
  lome_rsp_if.source      rsp_o
);
  import lome_pkg::*;

  state_e                    state_q, state_d;
  item_t                     cur_q, cur_d;
  logic [ORDER_CAPACITY-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]          bids_q, bids_d, asks_q, asks_d;
  logic [31:0]               trade_ctr_q, trade_ctr_d, seq_ctr_q, seq_ctr_d;
  logic [31:0]               arr_ctr_q, arr_ctr_d;
  logic [31:0]               rem_q, rem_d;
  logic [CNT_W-1:0]          trades_q, trades_d, emit_q, emit_d;
  rest_e                     status_q, status_d;
  kind_e                     kind_q, kind_d;
  logic [IDX_W-1:0]          scan_q, scan_d, chk_idx_q;
  logic                      chk_vld_q, chk_vld_d;
  logic                      best_found_q, best_found_d;
  logic [IDX_W-1:0]          best_idx_q, best_idx_d;
  entry_t                    best_q, best_d;
  logic                      id_found_q, id_found_d, free_found_q, free_found_d;
  logic [IDX_W-1:0]          id_idx_q, id_idx_d, free_idx_q, free_idx_d;
  entry_t                    id_ent_q, id_ent_d;
  logic                      out_valid_q, out_valid_d;
  result_t                   out_q, out_d;

  entry_t                    ent_mem [ORDER_CAPACITY];
  entry_t                    ent_rdata_q, ent_wdata;
  logic                      ent_we;
  logic [IDX_W-1:0]          ent_waddr;
  fill_t                     res_mem [ORDER_CAPACITY];
  fill_t                     res_rdata_q, res_wdata;
  logic                      res_we;

  logic [31:0] tq, rem_left, maker_left, seq_sel;
  logic        at_cap, emit_last, out_free, e_valid, cand, better;
  logic        dec_bid, dec_ask, inc_bid, inc_ask, clr;

  assign tq         = (rem_q < best_q.quantity) ? rem_q : best_q.quantity;
  assign rem_left   = rem_q - tq;
  assign maker_left = best_q.quantity - tq;
  assign at_cap     = trades_q == CNT_W'(ORDER_CAPACITY - 1);
  assign emit_last  = (trades_q == '0) || (emit_q == trades_q - CNT_W'(1));
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign seq_sel    = (cur_q.order_seq != '0) ? cur_q.order_seq : seq_ctr_q + 32'd1;
  assign deq_ready_o = state_q == ST_IDLE;

  assign e_valid = chk_vld_q && valid_q[chk_idx_q];
  assign cand = e_valid && (ent_rdata_q.side != cur_q.side) &&
                ((cur_q.side == SIDE_BID) ? (ent_rdata_q.price <= cur_q.price)
                                          : (ent_rdata_q.price >= cur_q.price));
  always_comb begin
    if (!best_found_q) begin
      better = 1'b1;
    end else if (ent_rdata_q.price != best_q.price) begin
      better = (cur_q.side == SIDE_BID) ? (ent_rdata_q.price < best_q.price)
                                        : (ent_rdata_q.price > best_q.price);
    end else begin
      better = ent_rdata_q.arrival < best_q.arrival;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (deq_i.valid) begin
          unique case (deq_i.item.command)
            CMD_ADD:    state_d = (deq_i.item.quantity != '0) ? ST_SCAN_B : ST_EMIT_RD;
            CMD_CANCEL: state_d = ST_SCAN_I;
            default:    state_d = ST_EMIT_RD;
          endcase
        end
      end
      ST_SCAN_B:  if (scan_q == IDX_W'(ORDER_CAPACITY - 1)) state_d = ST_DRAIN_B;
      ST_DRAIN_B: state_d = ST_MATCH;
      ST_MATCH: begin
        if (!best_found_q) begin
          state_d = ST_SCAN_I;
        end else if (rem_left == '0) begin
          state_d = ST_EMIT_RD;
        end else if (at_cap) begin
          state_d = ST_SCAN_I;
        end else begin
          state_d = ST_SCAN_B;
        end
      end
      ST_SCAN_I:  if (scan_q == IDX_W'(ORDER_CAPACITY - 1)) state_d = ST_DRAIN_I;
      ST_DRAIN_I: state_d = ST_RESOLVE;
      ST_RESOLVE: state_d = ST_EMIT_RD;
      ST_EMIT_RD: state_d = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_free) begin
          state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cur_d        = cur_q;
    valid_d      = valid_q;
    trade_ctr_d  = trade_ctr_q;
    seq_ctr_d    = seq_ctr_q;
    arr_ctr_d    = arr_ctr_q;
    rem_d        = rem_q;
    trades_d     = trades_q;
    emit_d       = emit_q;
    status_d     = status_q;
    kind_d       = kind_q;
    scan_d       = '0;
    chk_vld_d    = (state_q == ST_SCAN_B) || (state_q == ST_SCAN_I);
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    id_found_d   = id_found_q;
    id_idx_d     = id_idx_q;
    id_ent_d     = id_ent_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_d        = out_q;
    ent_we       = 1'b0;
    ent_waddr    = best_idx_q;
    ent_wdata    = best_q;
    res_we       = 1'b0;
    res_wdata    = '0;
    dec_bid      = 1'b0;
    dec_ask      = 1'b0;
    inc_bid      = 1'b0;
    inc_ask      = 1'b0;
    clr          = 1'b0;

    if (state_q inside {ST_SCAN_B, ST_DRAIN_B}) begin
      if (cand && better) begin
        best_found_d = 1'b1;
        best_idx_d   = chk_idx_q;
        best_d       = ent_rdata_q;
      end
    end else if (state_q inside {ST_SCAN_I, ST_DRAIN_I}) begin
      if (e_valid && (ent_rdata_q.oid == cur_q.oid) && !id_found_q) begin
        id_found_d = 1'b1;
        id_idx_d   = chk_idx_q;
        id_ent_d   = ent_rdata_q;
      end
      if (chk_vld_q && !valid_q[chk_idx_q] && !free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = chk_idx_q;
      end
    end else begin
      best_found_d = 1'b0;
      id_found_d   = 1'b0;
      free_found_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (deq_i.valid) begin
          cur_d    = deq_i.item;
          trades_d = '0;
          emit_d   = '0;
          status_d = REST_NONE;
          rem_d    = '0;
          kind_d   = KIND_ADD;
          unique case (deq_i.item.command)
            CMD_ADD:    rem_d = deq_i.item.quantity;
            CMD_CANCEL: kind_d = KIND_NOT_FOUND;
            default: begin
              kind_d  = KIND_CLEARED;
              valid_d = '0;
              clr     = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN_B, ST_SCAN_I: begin
        scan_d = (scan_q == IDX_W'(ORDER_CAPACITY - 1)) ? '0 : scan_q + IDX_W'(1);
      end
      ST_MATCH: begin
        if (best_found_q) begin
          trade_ctr_d        = trade_ctr_q + 32'd1;
          res_we             = 1'b1;
          res_wdata.trade_no = trade_ctr_q + 32'd1;
          res_wdata.price    = best_q.price;
          res_wdata.quantity = tq;
          res_wdata.maker_id = best_q.oid;
          trades_d           = trades_q + CNT_W'(1);
          rem_d              = rem_left;
          ent_we             = 1'b1;
          ent_waddr          = best_idx_q;
          ent_wdata.quantity = maker_left;
          if (maker_left == '0) begin
            valid_d[best_idx_q] = 1'b0;
            dec_bid = best_q.side == SIDE_BID;
            dec_ask = best_q.side == SIDE_ASK;
          end
        end
      end
      ST_RESOLVE: begin
        if (cur_q.command == CMD_CANCEL) begin
          if (id_found_q) begin
            kind_d            = KIND_CANCELLED;
            valid_d[id_idx_q] = 1'b0;
            dec_bid = id_ent_q.side == SIDE_BID;
            dec_ask = id_ent_q.side == SIDE_ASK;
          end
        end else begin
          ent_wdata.side      = cur_q.side;
          ent_wdata.price     = cur_q.price;
          ent_wdata.quantity  = rem_q;
          ent_wdata.oid       = cur_q.oid;
          ent_wdata.order_seq = seq_sel;
          ent_wdata.arrival   = arr_ctr_q;
          status_d            = REST_RESTED;
          if (id_found_q && (id_ent_q.side == cur_q.side) &&
              (id_ent_q.price == cur_q.price)) begin
            ent_we            = 1'b1;
            ent_waddr         = id_idx_q;
            ent_wdata.arrival = id_ent_q.arrival;
          end else if (id_found_q) begin
            ent_we    = 1'b1;
            ent_waddr = id_idx_q;
            arr_ctr_d = arr_ctr_q + 32'd1;
            dec_bid   = id_ent_q.side == SIDE_BID;
            dec_ask   = id_ent_q.side == SIDE_ASK;
            inc_bid   = cur_q.side == SIDE_BID;
            inc_ask   = cur_q.side == SIDE_ASK;
          end else if (free_found_q) begin
            ent_we              = 1'b1;
            ent_waddr           = free_idx_q;
            valid_d[free_idx_q] = 1'b1;
            arr_ctr_d           = arr_ctr_q + 32'd1;
            inc_bid             = cur_q.side == SIDE_BID;
            inc_ask             = cur_q.side == SIDE_ASK;
          end else begin
            status_d = REST_DROPPED;
          end
          if (status_d == REST_RESTED && cur_q.order_seq == '0) begin
            seq_ctr_d = seq_ctr_q + 32'd1;
          end
        end
      end
      ST_EMIT_WAIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.last        = emit_last;
          out_d.rest_status = emit_last ? status_q : REST_NONE;
          out_d.rested_quantity = emit_last ? rem_q : '0;
          out_d.bid_orders  = bids_q;
          out_d.ask_orders  = asks_q;
          if (trades_q == '0) begin
            out_d.kind           = kind_q;
            out_d.trade_no       = '0;
            out_d.trade_price    = '0;
            out_d.trade_quantity = '0;
            out_d.taker_id       = '0;
            out_d.maker_id       = '0;
          end else begin
            out_d.kind           = KIND_TRADE;
            out_d.trade_no       = res_rdata_q.trade_no;
            out_d.trade_price    = res_rdata_q.price;
            out_d.trade_quantity = res_rdata_q.quantity;
            out_d.taker_id       = cur_q.oid;
            out_d.maker_id       = res_rdata_q.maker_id;
          end
          emit_d = emit_last ? '0 : emit_q + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    bids_d = bids_q - CNT_W'(dec_bid) + CNT_W'(inc_bid);
    asks_d = asks_q - CNT_W'(dec_ask) + CNT_W'(inc_ask);
    if (clr) begin
      bids_d = '0;
      asks_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      bids_q       <= '0;
      asks_q       <= '0;
      trade_ctr_q  <= '0;
      seq_ctr_q    <= '0;
      arr_ctr_q    <= '0;
      trades_q     <= '0;
      emit_q       <= '0;
      scan_q       <= '0;
      chk_vld_q    <= 1'b0;
      best_found_q <= 1'b0;
      id_found_q   <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      bids_q       <= bids_d;
      asks_q       <= asks_d;
      trade_ctr_q  <= trade_ctr_d;
      seq_ctr_q    <= seq_ctr_d;
      arr_ctr_q    <= arr_ctr_d;
      trades_q     <= trades_d;
      emit_q       <= emit_d;
      scan_q       <= scan_d;
      chk_vld_q    <= chk_vld_d;
      best_found_q <= best_found_d;
      id_found_q   <= id_found_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    rem_q      <= rem_d;
    status_q   <= status_d;
    kind_q     <= kind_d;
    chk_idx_q  <= scan_q;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    id_idx_q   <= id_idx_d;
    id_ent_q   <= id_ent_d;
    free_idx_q <= free_idx_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_q <= ent_mem[scan_q];
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[trades_q[IDX_W-1:0]] <= res_wdata;
    end
    res_rdata_q <= res_mem[emit_q[IDX_W-1:0]];
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.kind            = out_q.kind;
  assign rsp_o.trade_no        = out_q.trade_no;
  assign rsp_o.trade_price     = 16'(out_q.trade_price);
  assign rsp_o.trade_quantity  = out_q.trade_quantity;
  assign rsp_o.taker_id        = out_q.taker_id;
  assign rsp_o.maker_id        = out_q.maker_id;
  assign rsp_o.rest_status     = out_q.rest_status;
  assign rsp_o.rested_quantity = out_q.rested_quantity;
  assign rsp_o.last            = out_q.last;
  assign rsp_o.bid_orders      = 7'(out_q.bid_orders);
  assign rsp_o.ask_orders      = 7'(out_q.ask_orders);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W + 1)'(bids_q) + (CNT_W + 1)'(asks_q)) <= (CNT_W + 1)'(ORDER_CAPACITY))
    else $error("resting order count exceeds capacity");

  a_trades_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trades_q <= CNT_W'(ORDER_CAPACITY))
    else $error("trade buffer overrun");

  a_maker_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MATCH && best_found_q) |-> (best_q.side != cur_q.side))
    else $error("maker on taker side");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_WAIT && trades_q != '0) |-> (emit_q < trades_q))
    else $error("emit index beyond trade count");

endmodule

### rtl/core/limit_order_matching_engine.sv
// Price-time priority limit order book: add, cancel and clear commands in, trade and
// status transactions out. The store holds ORDER_CAPACITY orders (64) and is searched one
// entry a cycle through a single read port, each search ending in a decision. An add of
// nonzero quantity runs best price searches, one per trade, until it is filled, no match
// is left or the trade buffer is full, then an id search to rest the remainder; a cancel
// runs one id search and a clear none. Results of a command are held in the trade buffer,
// each read out and then registered for output, and released only when the command has
// finished, since every transaction carries the final bid and ask counts.
// A two-entry command queue lets commands be accepted while the engine works; command 3
// is taken and discarded with no result.
module limit_order_matching_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  lome_req_if.sink   req_i,
  lome_rsp_if.source rsp_o
);
  import lome_pkg::*;

  fq_t  fq;
  logic deq_ready;

  lome_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .deq_o       (fq),
    .deq_ready_i (deq_ready)
  );

  lome_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .deq_i       (fq),
    .deq_ready_o (deq_ready),
    .rsp_o       (rsp_o)
  );

endmodule
